// File: rtl/nclg_pkg.sv
// Package for the noise channel generator: command and register codes,
// masks and reload constants. No dependencies.
package nclg_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_LENGTH   = 2'd0,
    REG_ENVELOPE = 2'd1,
    REG_POLY     = 2'd2,
    REG_CONTROL  = 2'd3
  } reg_sel_e;

  localparam logic [14:0] LFSR_WIDE_MASK   = 15'h4000;
  localparam logic [14:0] LFSR_NARROW_MASK = 15'h4040;
  localparam logic [6:0]  LEN_FULL         = 7'h40;
  localparam logic [6:0]  LEN_GLITCH       = 7'h3F;
  localparam logic [5:0]  LEN_LOAD_MASK    = 6'h3F;
  localparam logic [7:0]  ENV_DAC_MASK     = 8'hF8;
  localparam logic [7:0]  CTRL_READ_MASK   = 8'hBF;
  localparam logic [7:0]  WO_READ_VALUE    = 8'hFF;
  localparam logic [3:0]  VOL_MAX          = 4'hF;

endpackage

// File: rtl/noise_channel_lfsr_generator.sv
// Noise channel generator top level: 15/7-bit LFSR, period counter,
// envelope, length counter and register file. Depends on nclg_pkg.
//
// Usage: every input word is one command, tuser selects it: a 2 MHz tick,
// a frame-sequencer event, a register write (write_data in tdata) or a
// register read. Every command returns exactly one output word carrying the
// output level, the running flag and the read data (zero unless a read).
// Each accepted word goes into the input register, then through one pass of
// update logic into the result register.
// Throughput: one word per cycle while results are taken, set by the single
// update pass on the channel state; the next word sees all state left by the
// previous one. Reset clears all channel state and empties both registers;
// the tick phase starts at one. When the receiver stalls, the result is held
// and one more word is taken into the input register, after which
// s_axis_tready_o drops until the result is taken.
module noise_channel_lfsr_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] write_data
  input  logic [3:0]  s_axis_tuser_i,   // [1:0] cmd, [3:2] reg_sel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [3:0] level, [4] active, [12:5] read_data, rest 0
);
  import nclg_pkg::*;

  // input register
  logic       in_valid_q, in_valid_d;
  cmd_e       in_cmd_q, in_cmd_d;
  reg_sel_e   in_sel_q, in_sel_d;
  logic [7:0] in_data_q, in_data_d;

  // result register
  logic       out_valid_q, out_valid_d;
  logic [3:0] out_lvl_q, out_lvl_d;
  logic       out_act_q, out_act_d;
  logic [7:0] out_rd_q, out_rd_d;

  // channel state
  logic [14:0] shift_q, shift_d;
  logic        narrow_q, narrow_d;
  logic [18:0] reload_q, reload_d;
  logic [20:0] period_q, period_d;
  logic [3:0]  volume_q, volume_d;
  logic [2:0]  env_cnt_q, env_cnt_d;
  logic [6:0]  len_cnt_q, len_cnt_d;
  logic        len_en_q, len_en_d;
  logic        running_q, running_d;
  logic [3:0]  level_q, level_d;
  logic        half_q, half_d;
  logic [1:0]  align_q, align_d;
  logic [2:0]  fstep_q, fstep_d;
  logic [7:0]  env_reg_q, env_reg_d;
  logic [7:0]  poly_reg_q, poly_reg_d;
  logic [7:0]  ctrl_reg_q, ctrl_reg_d;

  logic advance;
  logic step;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = advance && in_valid_q;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'd0, out_rd_q, out_act_q, out_lvl_q};

  always_comb begin
    in_valid_d = in_valid_q;
    in_cmd_d   = in_cmd_q;
    in_sel_d   = in_sel_q;
    in_data_d  = in_data_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
      in_cmd_d   = cmd_e'(s_axis_tuser_i[1:0]);
      in_sel_d   = reg_sel_e'(s_axis_tuser_i[3:2]);
      in_data_d  = s_axis_tdata_i;
    end
  end

  // channel update for the word in the input register
  always_comb begin
    logic        fb;
    logic [14:0] fb_mask;
    logic [14:0] shifted;
    logic [3:0]  div;
    logic [18:0] div_shl;
    logic [3:0]  trig_off;
    logic        trig;
    logic [7:0]  rd;

    shift_d    = shift_q;
    narrow_d   = narrow_q;
    reload_d   = reload_q;
    period_d   = period_q;
    volume_d   = volume_q;
    env_cnt_d  = env_cnt_q;
    len_cnt_d  = len_cnt_q;
    len_en_d   = len_en_q;
    running_d  = running_q;
    level_d    = level_q;
    half_d     = half_q;
    align_d    = align_q;
    fstep_d    = fstep_q;
    env_reg_d  = env_reg_q;
    poly_reg_d = poly_reg_q;
    ctrl_reg_d = ctrl_reg_q;
    rd         = 8'd0;
    fb         = shift_q[0] ~^ shift_q[1];
    fb_mask    = narrow_q ? LFSR_NARROW_MASK : LFSR_WIDE_MASK;
    shifted    = {1'b0, shift_q[14:1]};
    div        = (in_data_q[2:0] == 3'd0) ? 4'd1 : {in_data_q[2:0], 1'b0};
    div_shl    = {15'd0, div} << in_data_q[7:4];
    trig       = in_data_q[7];
    trig_off   = 4'd6 - {3'd0, half_q};
    if (poly_reg_q[2:0] != 3'd0 && !align_q[1]) begin
      if (poly_reg_q[2:0] == 3'd1) trig_off = trig_off + 4'd2;
      else                          trig_off = trig_off - 4'd2;
    end
    if (running_q) trig_off = trig_off + 4'd2;

    unique case (in_cmd_q)
      CMD_TICK: begin
        half_d  = !half_q;
        align_d = align_q + 2'd1;
        if (running_q) begin
          if (period_q == 21'd0) begin
            period_d = {reload_q, 2'b11};
            shift_d  = fb ? (shifted | fb_mask) : (shifted & ~fb_mask);
            level_d  = shift_d[0] ? volume_q : 4'd0;
          end else begin
            period_d = period_q - 21'd1;
          end
        end
      end
      CMD_FRAME: begin
        fstep_d = fstep_q + 3'd1;
        if (fstep_d == 3'd0 && env_cnt_q != 3'd0) begin
          env_cnt_d = env_cnt_q - 3'd1;
          if (env_cnt_d == 3'd0) begin
            if (env_reg_q[3] && volume_q < VOL_MAX)        volume_d = volume_q + 4'd1;
            else if (!env_reg_q[3] && volume_q != 4'd0)    volume_d = volume_q - 4'd1;
            env_cnt_d = env_reg_q[2:0];
            level_d   = shift_q[0] ? volume_d : 4'd0;
          end
        end
        if (fstep_d[0] && len_en_q && len_cnt_q != 7'd0) begin
          len_cnt_d = len_cnt_q - 7'd1;
          if (len_cnt_d == 7'd0) begin
            running_d = 1'b0;
            level_d   = 4'd0;
          end
        end
      end
      CMD_WRITE: begin
        unique case (in_sel_q)
          REG_LENGTH: len_cnt_d = LEN_FULL - {1'b0, in_data_q[5:0] & LEN_LOAD_MASK};
          REG_ENVELOPE: begin
            env_reg_d = in_data_q;
            if ((in_data_q & ENV_DAC_MASK) == 8'd0) begin
              level_d   = 4'd0;
              running_d = 1'b0;
            end
          end
          REG_POLY: begin
            poly_reg_d = in_data_q;
            narrow_d   = in_data_q[3];
            reload_d   = div_shl - 19'd1;
          end
          REG_CONTROL: begin
            ctrl_reg_d = in_data_q;
            if (trig) begin
              shift_d   = 15'd0;
              period_d  = {1'b0, reload_q, 1'b0} + {17'd0, trig_off};
              volume_d  = env_reg_q[7:4];
              env_cnt_d = env_reg_q[2:0];
              if ((env_reg_q & ENV_DAC_MASK) != 8'd0) running_d = 1'b1;
              if (len_cnt_q == 7'd0) begin
                len_cnt_d = LEN_FULL;
                len_en_d  = 1'b0;
              end
            end
            // enabling length in an odd frame step clocks it once
            if (in_data_q[6] && !len_en_d && fstep_q[0] && len_cnt_d != 7'd0) begin
              len_cnt_d = len_cnt_d - 7'd1;
              if (len_cnt_d == 7'd0) begin
                if (trig) begin
                  len_cnt_d = LEN_GLITCH;
                end else begin
                  level_d   = 4'd0;
                  running_d = 1'b0;
                end
              end
            end
            len_en_d = in_data_q[6];
          end
          default: ;
        endcase
      end
      CMD_READ: begin
        unique case (in_sel_q)
          REG_LENGTH:   rd = WO_READ_VALUE;
          REG_ENVELOPE: rd = env_reg_q;
          REG_POLY:     rd = poly_reg_q;
          REG_CONTROL:  rd = ctrl_reg_q | CTRL_READ_MASK;
          default:      rd = 8'd0;
        endcase
      end
      default: ;
    endcase

    out_valid_d = out_valid_q;
    out_lvl_d   = out_lvl_q;
    out_act_d   = out_act_q;
    out_rd_d    = out_rd_q;
    if (advance) begin
      out_valid_d = in_valid_q;
      out_lvl_d   = level_d;
      out_act_d   = running_d;
      out_rd_d    = rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      shift_q     <= 15'd0;
      narrow_q    <= 1'b0;
      reload_q    <= 19'd0;
      period_q    <= 21'd0;
      volume_q    <= 4'd0;
      env_cnt_q   <= 3'd0;
      len_cnt_q   <= 7'd0;
      len_en_q    <= 1'b0;
      running_q   <= 1'b0;
      level_q     <= 4'd0;
      half_q      <= 1'b1;
      align_q     <= 2'd0;
      fstep_q     <= 3'd0;
      env_reg_q   <= 8'd0;
      poly_reg_q  <= 8'd0;
      ctrl_reg_q  <= 8'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (step) begin
        shift_q    <= shift_d;
        narrow_q   <= narrow_d;
        reload_q   <= reload_d;
        period_q   <= period_d;
        volume_q   <= volume_d;
        env_cnt_q  <= env_cnt_d;
        len_cnt_q  <= len_cnt_d;
        len_en_q   <= len_en_d;
        running_q  <= running_d;
        level_q    <= level_d;
        half_q     <= half_d;
        align_q    <= align_d;
        fstep_q    <= fstep_d;
        env_reg_q  <= env_reg_d;
        poly_reg_q <= poly_reg_d;
        ctrl_reg_q <= ctrl_reg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_cmd_q  <= in_cmd_d;
    in_sel_q  <= in_sel_d;
    in_data_q <= in_data_d;
    out_lvl_q <= out_lvl_d;
    out_act_q <= out_act_d;
    out_rd_q  <= out_rd_d;
  end

`ifndef NO_ASSERTIONS
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled while pipeline not full");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_cnt_q <= LEN_FULL)
    else $error("length counter above full scale");

  a_period_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_cmd_q == CMD_TICK && running_q && period_q == 21'd0)
    |=> period_q == {$past(reload_q), 2'b11})
    else $error("period counter not reloaded on expiry");

  a_trigger_clears_lfsr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_cmd_q == CMD_WRITE && in_sel_q == REG_CONTROL && in_data_q[7])
    |=> shift_q == 15'd0)
    else $error("trigger did not clear the shift register");

  a_frozen_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_cmd_q == CMD_TICK && !running_q) |=> $stable(period_q) && $stable(shift_q))
    else $error("stopped channel advanced its period or shift register");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Testbench for noise_channel_lfsr_generator: random and directed command words,
// checked word by word against a model of the channel. Depends on nclg_pkg and the RTL.
module tb;
  import nclg_pkg::*;

  typedef struct packed {
    logic [3:0] level;
    logic       active;
    logic [7:0] rd;
  } noise_result_t;

  class noise_channel_sb;
    logic [14:0] lfsr;
    logic        narrow;
    logic [18:0] reload;
    logic [20:0] period_cnt;
    logic [3:0]  volume;
    logic [2:0]  env_cnt;
    logic [6:0]  len_cnt;
    logic        len_en;
    logic        running;
    logic [3:0]  level;
    logic        half;
    logic [1:0]  align;
    logic [2:0]  frame_step;
    logic [7:0]  env_reg;
    logic [7:0]  poly_reg;
    logic [7:0]  ctrl_reg;
    noise_result_t expected_q[$];
    int errors = 0;

    function void clear_state();
      lfsr = '0; narrow = 0; reload = '0; period_cnt = '0; volume = '0;
      env_cnt = '0; len_cnt = '0; len_en = 0; running = 0; level = '0;
      half = 1; align = '0; frame_step = '0; env_reg = '0; poly_reg = '0;
      ctrl_reg = '0;
    endfunction

    function logic [3:0] sampled();
      return lfsr[0] ? volume : 4'd0;
    endfunction

    function void advance_tick();
      logic fb;
      half  = ~half;
      align = align + 2'd1;
      if (!running) return;
      if (period_cnt == '0) begin
        fb         = lfsr[0] ^ lfsr[1] ^ 1'b1;
        period_cnt = 21'(32'(reload) * 4 + 3);
        lfsr       = lfsr >> 1;
        if (fb)
          lfsr = lfsr | (narrow ? LFSR_NARROW_MASK : LFSR_WIDE_MASK);
        else
          lfsr = lfsr & ~(narrow ? LFSR_NARROW_MASK : LFSR_WIDE_MASK);
        level = sampled();
      end else begin
        period_cnt = period_cnt - 21'd1;
      end
    endfunction

    function void advance_frame();
      frame_step = frame_step + 3'd1;
      if (frame_step == '0 && env_cnt != '0) begin
        env_cnt = env_cnt - 3'd1;
        if (env_cnt == '0) begin
          if (env_reg[3] && volume < VOL_MAX)
            volume = volume + 4'd1;
          else if (!env_reg[3] && volume > 4'd0)
            volume = volume - 4'd1;
          env_cnt = env_reg[2:0];
          level   = sampled();
        end
      end
      if (frame_step[0] && len_en && len_cnt != '0) begin
        len_cnt = len_cnt - 7'd1;
        if (len_cnt == '0) begin
          running = 0;
          level   = '0;
        end
      end
    endfunction

    function void start_channel();
      int unsigned cnt;
      lfsr = '0;
      cnt  = 32'(reload) * 2 + 6 - 32'(half);
      if (poly_reg[2:0] != 3'd0 && !align[1]) begin
        if (poly_reg[2:0] == 3'd1) cnt = cnt + 2;
        else cnt = cnt - 2;
      end
      if (running) cnt = cnt + 2;
      period_cnt = cnt[20:0];
      volume     = env_reg[7:4];
      env_cnt    = env_reg[2:0];
      if ((env_reg & ENV_DAC_MASK) != '0) running = 1;
      if (len_cnt == '0) begin
        len_cnt = LEN_FULL;
        len_en  = 0;
      end
    endfunction

    function void apply_write(reg_sel_e sel, logic [7:0] v);
      int unsigned div;
      case (sel)
        REG_LENGTH: len_cnt = LEN_FULL - 7'(v[5:0] & LEN_LOAD_MASK);
        REG_ENVELOPE: begin
          env_reg = v;
          if ((v & ENV_DAC_MASK) == '0) begin
            level   = '0;
            running = 0;
          end
        end
        REG_POLY: begin
          poly_reg = v;
          narrow   = v[3];
          div      = 32'(v[2:0]) << 1;
          if (div == 0) div = 1;
          reload   = 19'((div << v[7:4]) - 1);
        end
        default: begin
          ctrl_reg = v;
          if (v[7]) start_channel();
          if (v[6] && !len_en && frame_step[0] && len_cnt != '0) begin
            len_cnt = len_cnt - 7'd1;
            if (len_cnt == '0) begin
              if (v[7]) begin
                len_cnt = LEN_GLITCH;
              end else begin
                level   = '0;
                running = 0;
              end
            end
          end
          len_en = v[6];
        end
      endcase
    endfunction

    function logic [7:0] reg_value(reg_sel_e sel);
      case (sel)
        REG_LENGTH:   return WO_READ_VALUE;
        REG_ENVELOPE: return env_reg;
        REG_POLY:     return poly_reg;
        default:      return ctrl_reg | CTRL_READ_MASK;
      endcase
    endfunction

    function void note_word(cmd_e cmd, reg_sel_e sel, logic [7:0] v);
      noise_result_t r;
      r.rd = '0;
      case (cmd)
        CMD_TICK:  advance_tick();
        CMD_FRAME: advance_frame();
        CMD_WRITE: apply_write(sel, v);
        default:   r.rd = reg_value(sel);
      endcase
      r.level  = level;
      r.active = running;
      expected_q.push_back(r);
    endfunction

    task report(string what, int got, int want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_word(logic [15:0] w);
      noise_result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected word", w, 0);
        return;
      end
      want = expected_q.pop_front();
      if (w[3:0] !== want.level) report("level", w[3:0], want.level);
      if (w[4] !== want.active) report("active", w[4], want.active);
      if (w[12:5] !== want.rd) report("read_data", w[12:5], want.rd);
      if (w[15:13] !== 3'd0) report("padding", w[15:13], 0);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_axis_tready_o;
  logic [7:0]  s_data;
  logic [3:0]  s_user;
  logic        m_axis_tvalid_o;
  logic        m_ready;
  logic [15:0] m_axis_tdata_o;

  noise_channel_sb sb = new;
  int src_idle  = 19;
  int sink_idle = 71;
  int words_sent = 0;

  localparam int NUM_WORDS = 1750;

  noise_channel_lfsr_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) m_ready = ($urandom_range(99) >= sink_idle);

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid_o && m_ready) sb.check_word(m_axis_tdata_o);

  task send_word(cmd_e cmd, reg_sel_e sel, logic [7:0] v);
    while ($urandom_range(99) < src_idle) begin
      s_valid = 0;
      @(negedge clk_i);
    end
    s_valid = 1;
    s_user  = {sel, cmd};
    s_data  = v;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_word(cmd, sel, v);
    words_sent++;
    @(negedge clk_i);
  endtask

  task send_random();
    send_word(cmd_e'($urandom_range(3)), reg_sel_e'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  // trigger a freshly set-up channel, then let it run with ticks and frame events, plus occasional reads and writes
  task run_channel();
    logic [7:0] v;
    int body;
    int frame_pct;
    v = 8'($urandom_range(255));
    if ($urandom_range(9) != 0) v[7:4] = v[7:4] | 4'h1;
    send_word(CMD_WRITE, REG_ENVELOPE, v);
    v = 8'($urandom_range(255));
    if ($urandom_range(9) != 0) v[7:4] = 4'($urandom_range(1));
    send_word(CMD_WRITE, REG_POLY, v);
    v = 8'($urandom_range(255));
    if ($urandom_range(1)) v[5:0] = 6'($urandom_range(56, 63));
    send_word(CMD_WRITE, REG_LENGTH, v);
    if ($urandom_range(1)) send_word(CMD_FRAME, REG_LENGTH, 8'($urandom_range(255)));
    v = 8'($urandom_range(255));
    v[7] = 1;
    send_word(CMD_WRITE, REG_CONTROL, v);
    body      = $urandom_range(20, 80);
    frame_pct = $urandom_range(10, 40);
    repeat (body) begin
      if ($urandom_range(99) < frame_pct)
        send_word(CMD_FRAME, reg_sel_e'($urandom_range(3)), 8'($urandom_range(255)));
      else if ($urandom_range(99) < 85)
        send_word(CMD_TICK, reg_sel_e'($urandom_range(3)), 8'($urandom_range(255)));
      else if ($urandom_range(1))
        send_word(CMD_READ, reg_sel_e'($urandom_range(3)), 8'($urandom_range(255)));
      else
        send_word(CMD_WRITE, reg_sel_e'($urandom_range(3)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    rst_ni  = 0;
    s_valid = 0;
    s_data  = '0;
    s_user  = '0;
    m_ready = 0;
    sb.clear_state();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    send_word(CMD_READ, REG_LENGTH, 8'h00);
    send_word(CMD_READ, REG_ENVELOPE, 8'hFF);
    send_word(CMD_READ, REG_POLY, 8'h00);
    send_word(CMD_READ, REG_CONTROL, 8'hFF);
    send_word(CMD_WRITE, REG_ENVELOPE, 8'hF0);
    send_word(CMD_WRITE, REG_POLY, 8'h08);
    send_word(CMD_WRITE, REG_LENGTH, 8'h3F);
    send_word(CMD_FRAME, REG_LENGTH, 8'h00);
    send_word(CMD_WRITE, REG_CONTROL, 8'hC0);
    repeat (4) send_word(CMD_TICK, REG_LENGTH, 8'h00);
    send_word(CMD_FRAME, REG_CONTROL, 8'h00);
    send_word(CMD_FRAME, REG_CONTROL, 8'h00);
    send_word(CMD_WRITE, REG_ENVELOPE, 8'h00);
    send_word(CMD_READ, REG_ENVELOPE, 8'h00);
    send_word(CMD_WRITE, REG_POLY, 8'hFF);
    send_word(CMD_READ, REG_POLY, 8'h00);
    send_word(CMD_WRITE, REG_LENGTH, 8'h00);
    send_word(CMD_WRITE, REG_ENVELOPE, 8'h0F);
    send_word(CMD_WRITE, REG_ENVELOPE, 8'h19);
    send_word(CMD_WRITE, REG_CONTROL, 8'hFF);
    send_word(CMD_READ, REG_CONTROL, 8'h00);
    send_word(CMD_TICK, REG_CONTROL, 8'hFF);

    while (words_sent < NUM_WORDS) begin
      if (words_sent < NUM_WORDS / 3) begin
        src_idle = 19; sink_idle = 71;
      end else if (words_sent < 2 * NUM_WORDS / 3) begin
        src_idle = 71; sink_idle = 19;
      end else begin
        src_idle = 0; sink_idle = 0;
      end
      if ($urandom_range(99) < 65)
        run_channel();
      else
        repeat ($urandom_range(1, 10)) send_random();
    end
    s_valid = 0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
